// ===== hw/rtl/chd_pkg.sv =====
`timescale 1ns / 1ps

package chd_pkg;

    localparam int unsigned ACC_W   = 18;
    localparam int unsigned LEN_W   = 17;
    localparam int unsigned CNT_W   = 9;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    localparam logic [ACC_W-1:0] ACC_MAX          = '1;
    localparam logic [LEN_W-1:0] SIZE_LIMIT_RST   = 17'h10000;
    localparam logic [CNT_W-1:0] CHUNK_LIMIT_RST  = 9'h100;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Register index, taken from paddr[2]
    localparam logic REG_SIZE_LIMIT  = 1'b0;
    localparam logic REG_CHUNK_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        PH_HEX_FIRST = 3'd0,
        PH_HEX_MORE  = 3'd1,
        PH_CR        = 3'd2,
        PH_PAYLOAD   = 3'd3,
        PH_TRAIL1    = 3'd4,
        PH_TRAIL2    = 3'd5,
        PH_DONE      = 3'd6,
        PH_ERROR     = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_FINISH  = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_BAD_HDR   = 2'd1,
        ERR_TOO_LONG  = 2'd2,
        ERR_LIMIT     = 2'd3
    } t_err;

    typedef struct packed {
        logic [LEN_W-1:0] size_limit;
        logic [CNT_W-1:0] chunk_limit;
    } t_cfg;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       payload_byte;
        logic             last_of_chunk;
        logic [LEN_W-1:0] chunk_length;
        t_err             error_code;
    } t_result;

    // Lower-case hex digit decode: {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, b[3:0]};
        end else if (b inside {[8'h61:8'h66]}) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/chd_cfg.sv =====
`timescale 1ns / 1ps

module chd_cfg import chd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_limit  <= SIZE_LIMIT_RST;
            r_cfg.chunk_limit <= CHUNK_LIMIT_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_SIZE_LIMIT) begin
                r_cfg.size_limit <= pwdata[LEN_W-1:0];
            end else begin
                r_cfg.chunk_limit <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_CHUNK_LIMIT) begin
            prdata = {{(APB_DW-CNT_W){1'b0}}, r_cfg.chunk_limit};
        end else begin
            prdata = {{(APB_DW-LEN_W){1'b0}}, r_cfg.size_limit};
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/chd_in_stage.sv =====
`timescale 1ns / 1ps

module chd_in_stage import chd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_step,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Refill in the same cycle the held byte is consumed
    assign o_ready = !r_valid || i_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_step) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== hw/rtl/chd_parser.sv =====
`timescale 1ns / 1ps

module chd_parser import chd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase           r_phase,  n_phase;
    logic [ACC_W-1:0] r_accum,  n_accum;
    logic [LEN_W-1:0] r_left,   n_left;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             r_final,  n_final;
    t_err             r_err,    n_err;

    logic [4:0]       hex;
    logic             is_digit;
    logic [ACC_W-1:0] acc_sat;
    logic             at_limit;
    logic             too_long;
    logic [LEN_W-1:0] left_dec;

    assign hex      = hex_decode(i_byte);
    assign is_digit = hex[4];
    // Saturate rather than wrap once the top nibble would shift out
    assign acc_sat  = (r_accum[ACC_W-1:ACC_W-4] != 4'd0) ? ACC_MAX
                                                         : {r_accum[ACC_W-5:0], hex[3:0]};
    assign at_limit = (r_count >= i_cfg.chunk_limit);
    assign too_long = (r_accum > {1'b0, i_cfg.size_limit});
    assign left_dec = r_left - 1'b1;

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_accum = r_accum;
        n_left  = r_left;
        n_count = r_count;
        n_final = r_final;
        n_err   = r_err;
        case (r_phase)
            PH_HEX_FIRST: begin
                if (at_limit) begin
                    n_phase = PH_ERROR;
                    n_err   = ERR_LIMIT;
                end else if (!is_digit) begin
                    n_phase = PH_ERROR;
                    n_err   = ERR_BAD_HDR;
                end else begin
                    n_accum = {{(ACC_W-4){1'b0}}, hex[3:0]};
                    n_phase = PH_HEX_MORE;
                end
            end
            PH_HEX_MORE, PH_CR: begin
                if (r_phase == PH_HEX_MORE && is_digit) begin
                    n_accum = acc_sat;
                end else if (i_byte == CHAR_CR) begin
                    n_phase = PH_CR;
                end else if (i_byte != CHAR_LF) begin
                    n_phase = PH_ERROR;
                    n_err   = ERR_BAD_HDR;
                end else if (too_long) begin
                    n_phase = PH_ERROR;
                    n_err   = ERR_TOO_LONG;
                end else begin
                    n_count = r_count + 1'b1;
                    n_left  = r_accum[LEN_W-1:0];
                    if (r_accum[LEN_W-1:0] == '0) begin
                        n_final = 1'b1;
                        n_phase = PH_TRAIL1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_left = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_TRAIL1;
                end
            end
            PH_TRAIL1: n_phase = PH_TRAIL2;
            PH_TRAIL2: n_phase = r_final ? PH_DONE : PH_HEX_FIRST;
            PH_DONE:   n_phase = PH_DONE;
            default:   n_phase = PH_ERROR;
        endcase
    end

    // Result for the byte under decode
    always_comb begin
        o_res_valid         = 1'b0;
        o_res.kind          = KIND_PAYLOAD;
        o_res.payload_byte  = 8'd0;
        o_res.last_of_chunk = 1'b0;
        o_res.chunk_length  = '0;
        o_res.error_code    = ERR_NONE;
        case (r_phase)
            PH_HEX_FIRST: begin
                if (at_limit) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_LIMIT;
                end else if (!is_digit) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_BAD_HDR;
                end
            end
            PH_HEX_MORE, PH_CR: begin
                if (!(r_phase == PH_HEX_MORE && is_digit) && i_byte != CHAR_CR) begin
                    o_res_valid = 1'b1;
                    if (i_byte != CHAR_LF) begin
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_BAD_HDR;
                    end else if (too_long) begin
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_TOO_LONG;
                    end else begin
                        o_res.kind         = KIND_HEADER;
                        o_res.chunk_length = r_accum[LEN_W-1:0];
                    end
                end
            end
            PH_PAYLOAD: begin
                o_res_valid         = 1'b1;
                o_res.kind          = KIND_PAYLOAD;
                o_res.payload_byte  = i_byte;
                o_res.last_of_chunk = (left_dec == '0);
            end
            PH_TRAIL2: begin
                if (r_final) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_FINISH;
                end
            end
            PH_ERROR: begin
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_ERROR;
                o_res.error_code = r_err;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEX_FIRST;
            r_accum <= '0;
            r_left  <= '0;
            r_count <= '0;
            r_final <= 1'b0;
            r_err   <= ERR_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_left  <= n_left;
            r_count <= n_count;
            r_final <= n_final;
            r_err   <= n_err;
        end
    end

endmodule

// ===== hw/rtl/chd_out_stage.sv =====
`timescale 1ns / 1ps

module chd_out_stage import chd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== hw/rtl/http_chunked_decoder.sv =====
`timescale 1ns / 1ps

// HTTP chunked-body decoder. Feed raw body bytes on the s_axis side, one byte
// per request; the block takes one byte every clock and produces at most one
// result request per byte on the m_axis side, passed on through one input
// register and then one result register. Throughput is one byte per clock
// as long as m_axis_tready is high; a stall on the result side holds the
// input register and then drops s_axis_tready. Each chunk header
// (lower-case hex digits, optional CR bytes, one LF) yields a header result
// with the length; payload bytes follow as payload results, the last one
// flagged on tlast; the two bytes after a payload are skipped unchecked. A
// zero-length header ends the stream with a finish result after its two
// trailer bytes, and all later bytes are dropped. Errors (bad header byte,
// length above size_limit, chunk_limit headers already seen) are sticky:
// every later byte returns the same error until reset. Registers over APB:
// 0x0 size_limit (17 bits, reset 65536), 0x4 chunk_limit (9 bits, reset 256).
// Write them only while the stream is idle. No clearing pass after reset.

module http_chunked_decoder import chd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input byte stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
    // Result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [7:0] payload_byte, [24:8] chunk_length,
                                              // [26:25] error_code, [31:27] zero
    output logic [1:0]        m_axis_tuser,   // [1:0] kind
    output logic              m_axis_tlast,   // last_of_chunk
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg       cfg;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       step;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    chd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Advance the held byte whenever the result register can take its result
    assign step = in_valid && out_free;

    chd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_step  (step),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    chd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    chd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (m_axis_tready),
        .o_free      (out_free),
        .o_valid     (m_axis_tvalid),
        .o_res       (out_res)
    );

    // Pack result fields, payload_byte in the lowest bits
    assign m_axis_tdata = {5'd0, out_res.error_code, out_res.chunk_length,
                           out_res.payload_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last_of_chunk;

endmodule
